>>> rtl/ptd_pkg.sv
// ptd_pkg: widths, payload structs, region codes and helpers for the
// point-triangle squared distance pipeline. No dependencies.
`default_nettype none

package ptd_pkg;

  // input coordinate format
  localparam int CoordWidth   = 24;
  // fraction bits kept for the edge parameter t
  localparam int EdgeFrac     = 24;
  // result width, unsigned, saturating
  localparam int DistWidth    = 52;
  // operand slice width inside the pipelined multipliers
  localparam int PieceWidth   = 26;

  // derived datapath widths
  localparam int DiffWidth    = CoordWidth + 1;
  localparam int DotWidth     = 2 * DiffWidth + 2;
  localparam int NormWidth    = 2 * DiffWidth + 1;
  localparam int VolWidth     = 2 * DotWidth + 1;
  localparam int NnWidth      = 2 * NormWidth + 2;
  localparam int PdWidth      = DiffWidth + NormWidth + 2;
  localparam int Pd2Width     = 2 * PdWidth;
  localparam int NumWidth     = DotWidth + 1;
  localparam int DenWidth     = DotWidth + 2;
  localparam int TWidth       = EdgeFrac + 1;
  localparam int OffWidth     = DiffWidth + TWidth + 2;
  localparam int SqWidth      = 2 * OffWidth + 2;
  localparam int FaceRemWidth = (NnWidth > Pd2Width - DistWidth) ? NnWidth
                                                                : Pd2Width - DistWidth;

  typedef enum logic [2:0] {
    RegionVertexA = 3'd0,
    RegionVertexB = 3'd1,
    RegionEdgeAB  = 3'd2,
    RegionVertexC = 3'd3,
    RegionEdgeAC  = 3'd4,
    RegionEdgeBC  = 3'd5,
    RegionFace    = 3'd6
  } region_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] point_z;
    logic signed [CoordWidth-1:0] vertex_a_x;
    logic signed [CoordWidth-1:0] vertex_a_y;
    logic signed [CoordWidth-1:0] vertex_a_z;
    logic signed [CoordWidth-1:0] vertex_b_x;
    logic signed [CoordWidth-1:0] vertex_b_y;
    logic signed [CoordWidth-1:0] vertex_b_z;
    logic signed [CoordWidth-1:0] vertex_c_x;
    logic signed [CoordWidth-1:0] vertex_c_y;
    logic signed [CoordWidth-1:0] vertex_c_z;
  } ptd_in_t;

  typedef struct packed {
    logic [DistWidth-1:0] distance_squared;
    region_e              closest_region;
    logic                 degenerate;
  } ptd_out_t;

  // exact coordinate difference a - b
  function automatic logic [DiffWidth-1:0] vdiff(input logic signed [CoordWidth-1:0] a,
                                                 input logic signed [CoordWidth-1:0] b);
    vdiff = DiffWidth'(a) - DiffWidth'(b);
  endfunction

endpackage

`default_nettype wire

>>> rtl/point_triangle_distance_squared.sv
// Throughput: one word per cycle while the output is not stalled; the 53-stage face divider sets the depth.
// A stall at the output freezes the whole pipe, nothing is lost or repeated.
// Reset clears only the valid bits; payload registers are not reset.
// Depends on ptd_pkg, ptd_dly, ptd_mul and ptd_div.
`default_nettype none

module point_triangle_distance_squared (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ptd_pkg::ptd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ptd_pkg::ptd_out_t      out_data_o
);

  import ptd_pkg::*;

  localparam int NumVec    = 6;
  localparam int NumDot    = 9;
  localparam int SelStage  = 8;
  localparam int FaceStage = SelStage + 2 + DistWidth + 1;
  localparam int OutStage  = FaceStage + 1;
  localparam int EdgeStage = SelStage + TWidth + 6;
  localparam int TailDelay = FaceStage - EdgeStage;
  localparam int MetaDelay = FaceStage - SelStage;
  localparam int SDelay    = TWidth + 2;
  localparam int MetaWidth = 3 + 1 + DotWidth;

  // vector slots: 0 ap, 1 bp, 2 cp, 3 ab, 4 ac, 5 bc
  // dots: d1..d6, then ap.ap, bp.bp, cp.cp
  localparam int DotL [NumDot] = '{3, 4, 3, 4, 3, 4, 0, 1, 2};
  localparam int DotR [NumDot] = '{0, 0, 1, 1, 2, 2, 0, 1, 2};
  // vc, vb, va as prod[j] - prod[j+3]
  localparam int VolL [6] = '{0, 4, 2, 2, 0, 4};
  localparam int VolR [6] = '{3, 1, 5, 1, 5, 3};

  logic                en;
  logic [OutStage-1:0] vld_q;

  // whole pipe advances unless the output word is held
  assign en          = ~vld_q[OutStage-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[OutStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[OutStage-2:0], in_valid_i};
    end
  end

  // stage 1: edge and offset vectors
  logic [NumVec-1:0][2:0][DiffWidth-1:0] vec_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_q[0][0] <= vdiff(in_data_i.point_x, in_data_i.vertex_a_x);
      vec_q[0][1] <= vdiff(in_data_i.point_y, in_data_i.vertex_a_y);
      vec_q[0][2] <= vdiff(in_data_i.point_z, in_data_i.vertex_a_z);
      vec_q[1][0] <= vdiff(in_data_i.point_x, in_data_i.vertex_b_x);
      vec_q[1][1] <= vdiff(in_data_i.point_y, in_data_i.vertex_b_y);
      vec_q[1][2] <= vdiff(in_data_i.point_z, in_data_i.vertex_b_z);
      vec_q[2][0] <= vdiff(in_data_i.point_x, in_data_i.vertex_c_x);
      vec_q[2][1] <= vdiff(in_data_i.point_y, in_data_i.vertex_c_y);
      vec_q[2][2] <= vdiff(in_data_i.point_z, in_data_i.vertex_c_z);
      vec_q[3][0] <= vdiff(in_data_i.vertex_b_x, in_data_i.vertex_a_x);
      vec_q[3][1] <= vdiff(in_data_i.vertex_b_y, in_data_i.vertex_a_y);
      vec_q[3][2] <= vdiff(in_data_i.vertex_b_z, in_data_i.vertex_a_z);
      vec_q[4][0] <= vdiff(in_data_i.vertex_c_x, in_data_i.vertex_a_x);
      vec_q[4][1] <= vdiff(in_data_i.vertex_c_y, in_data_i.vertex_a_y);
      vec_q[4][2] <= vdiff(in_data_i.vertex_c_z, in_data_i.vertex_a_z);
      vec_q[5][0] <= vdiff(in_data_i.vertex_c_x, in_data_i.vertex_b_x);
      vec_q[5][1] <= vdiff(in_data_i.vertex_c_y, in_data_i.vertex_b_y);
      vec_q[5][2] <= vdiff(in_data_i.vertex_c_z, in_data_i.vertex_b_z);
    end
  end

  // stages 2-3: dot and cross products
  logic signed [2*DiffWidth-1:0] dprod [NumDot][3];
  logic signed [2*DiffWidth-1:0] nprod [3][2];

  for (genvar k = 0; k < NumDot; k++) begin : g_dot
    for (genvar c = 0; c < 3; c++) begin : g_cmp
      ptd_mul #(.WA(DiffWidth), .WB(DiffWidth)) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   ($signed(vec_q[DotL[k]][c])),
        .b_i   ($signed(vec_q[DotR[k]][c])),
        .p_o   (dprod[k][c])
      );
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_cross
    ptd_mul #(.WA(DiffWidth), .WB(DiffWidth)) u_plus (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(vec_q[3][(c+1)%3])),
      .b_i   ($signed(vec_q[4][(c+2)%3])),
      .p_o   (nprod[c][0])
    );
    ptd_mul #(.WA(DiffWidth), .WB(DiffWidth)) u_minus (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(vec_q[3][(c+2)%3])),
      .b_i   ($signed(vec_q[4][(c+1)%3])),
      .p_o   (nprod[c][1])
    );
  end

  // stage 4: dot sums and the normal
  logic [NumDot-1:0][DotWidth-1:0] dot_q;
  logic [2:0][NormWidth-1:0]       nrm_q;
  logic [2:0][DiffWidth-1:0]       ap4;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NumDot; k++) begin
        dot_q[k] <= DotWidth'(dprod[k][0]) + DotWidth'(dprod[k][1])
                    + DotWidth'(dprod[k][2]);
      end
      for (int c = 0; c < 3; c++) begin
        nrm_q[c] <= NormWidth'(nprod[c][0]) - NormWidth'(nprod[c][1]);
      end
    end
  end

  ptd_dly #(.WIDTH(3 * DiffWidth), .DEPTH(3)) u_ap_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (vec_q[0]),
    .q_o   (ap4)
  );

  // stages 5-6: region products, normal length and plane distance
  logic signed [2*DotWidth-1:0]          vprod  [6];
  logic signed [2*NormWidth-1:0]         nnprod [3];
  logic signed [DiffWidth+NormWidth-1:0] pdprod [3];

  for (genvar j = 0; j < 6; j++) begin : g_vol
    ptd_mul #(.WA(DotWidth), .WB(DotWidth)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(dot_q[VolL[j]])),
      .b_i   ($signed(dot_q[VolR[j]])),
      .p_o   (vprod[j])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_face
    ptd_mul #(.WA(NormWidth), .WB(NormWidth)) u_nn (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(nrm_q[c])),
      .b_i   ($signed(nrm_q[c])),
      .p_o   (nnprod[c])
    );
    ptd_mul #(.WA(DiffWidth), .WB(NormWidth)) u_pd (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(ap4[c])),
      .b_i   ($signed(nrm_q[c])),
      .p_o   (pdprod[c])
    );
  end

  // stage 7: sums
  logic [2:0][VolWidth-1:0]        vol_q;
  logic [NnWidth-1:0]              nn_q;
  logic [PdWidth-1:0]              pd_q;
  logic [NumDot-1:0][DotWidth-1:0] dot7;
  logic [NumVec-1:0][2:0][DiffWidth-1:0] vec7;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        vol_q[j] <= VolWidth'(vprod[j]) - VolWidth'(vprod[j+3]);
      end
      nn_q <= NnWidth'(nnprod[0]) + NnWidth'(nnprod[1]) + NnWidth'(nnprod[2]);
      pd_q <= PdWidth'(pdprod[0]) + PdWidth'(pdprod[1]) + PdWidth'(pdprod[2]);
    end
  end

  ptd_dly #(.WIDTH(NumDot * DotWidth), .DEPTH(3)) u_dot_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dot_q),
    .q_o   (dot7)
  );

  ptd_dly #(.WIDTH(NumVec * 3 * DiffWidth), .DEPTH(6)) u_vec_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (vec_q),
    .q_o   (vec7)
  );

  // stage 8: region tests in priority order, edge operand selection
  region_e                   region_d, region_q;
  logic                      deg_d, deg_q;
  logic [DotWidth-1:0]       vdist_d, vdist_q;
  logic [NumWidth-1:0]       num_d, num_q;
  logic [DenWidth-1:0]       den_d, den_q;
  logic [2:0][DiffWidth-1:0] s_d, s_q, e_d, e_q;
  logic [PdWidth-1:0]        pd8_q;
  logic [NnWidth-1:0]        nn8_q;

  always_comb begin
    logic signed [NumWidth-1:0] e1, e2, den_ab, den_ac;
    logic [DotWidth-1:0] d1, d2, d3, d4, d5, d6;
    logic d1_le0, d2_le0, d3_le0, d6_le0, e1_le0, e2_le0;
    logic d1_ge0, d2_ge0, d3_ge0, d6_ge0;
    logic vc_le0, vb_le0, va_le0;
    d1 = dot7[0];
    d2 = dot7[1];
    d3 = dot7[2];
    d4 = dot7[3];
    d5 = dot7[4];
    d6 = dot7[5];
    e1     = NumWidth'($signed(d4)) - NumWidth'($signed(d3));
    e2     = NumWidth'($signed(d5)) - NumWidth'($signed(d6));
    den_ab = NumWidth'($signed(d1)) - NumWidth'($signed(d3));
    den_ac = NumWidth'($signed(d2)) - NumWidth'($signed(d6));
    d1_ge0 = ~d1[DotWidth-1];
    d2_ge0 = ~d2[DotWidth-1];
    d3_ge0 = ~d3[DotWidth-1];
    d6_ge0 = ~d6[DotWidth-1];
    d1_le0 = d1[DotWidth-1] | (d1 == '0);
    d2_le0 = d2[DotWidth-1] | (d2 == '0);
    d3_le0 = d3[DotWidth-1] | (d3 == '0);
    d6_le0 = d6[DotWidth-1] | (d6 == '0);
    e1_le0 = e1[NumWidth-1] | (e1 == '0);
    e2_le0 = e2[NumWidth-1] | (e2 == '0);
    vc_le0 = vol_q[0][VolWidth-1] | (vol_q[0] == '0);
    vb_le0 = vol_q[1][VolWidth-1] | (vol_q[1] == '0);
    va_le0 = vol_q[2][VolWidth-1] | (vol_q[2] == '0);

    region_d = RegionFace;
    vdist_d  = dot7[6];
    num_d    = '0;
    den_d    = '0;
    s_d      = vec7[0];
    e_d      = vec7[3];
    if (d1_le0 && d2_le0) begin
      region_d = RegionVertexA;
    end else if (d3_ge0 && e1_le0) begin
      region_d = RegionVertexB;
      vdist_d  = dot7[7];
    end else if (vc_le0 && d1_ge0 && d3_le0) begin
      region_d = RegionEdgeAB;
      num_d    = NumWidth'(d1);
      den_d    = DenWidth'(den_ab);
    end else if (d6_ge0 && e2_le0) begin
      region_d = RegionVertexC;
      vdist_d  = dot7[8];
    end else if (vb_le0 && d2_ge0 && d6_le0) begin
      region_d = RegionEdgeAC;
      num_d    = NumWidth'(d2);
      den_d    = DenWidth'(den_ac);
      e_d      = vec7[4];
    end else if (va_le0 && !e1[NumWidth-1] && !e2[NumWidth-1]) begin
      region_d = RegionEdgeBC;
      num_d    = e1;
      den_d    = DenWidth'(e1) + DenWidth'(e2);
      s_d      = vec7[1];
      e_d      = vec7[5];
    end
    deg_d = (region_d == RegionFace) && (nn_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      region_q <= region_d;
      deg_q    <= deg_d;
      vdist_q  <= vdist_d;
      num_q    <= num_d;
      den_q    <= den_d;
      s_q      <= s_d;
      e_q      <= e_d;
      pd8_q    <= pd_q;
      nn8_q    <= nn_q;
    end
  end

  // edge path: t = floor(num * 2^24 / den)
  logic [TWidth-1:0]         tq, t_eff;
  logic [2:0][DiffWidth-1:0] e33, s35;
  logic                      dz33;

  ptd_div #(.DW(DenWidth), .FEED(EdgeFrac)) u_edge_div (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (DenWidth'(num_q)),
    .den_i (den_q),
    .low_i ('0),
    .quo_o (tq)
  );

  ptd_dly #(.WIDTH(3 * DiffWidth + 1), .DEPTH(TWidth)) u_e_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({e_q, (den_q == '0)}),
    .q_o   ({e33, dz33})
  );

  ptd_dly #(.WIDTH(3 * DiffWidth), .DEPTH(SDelay)) u_s_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (s_q),
    .q_o   (s35)
  );

  // zero-length edge measures to the edge start
  assign t_eff = dz33 ? '0 : tq;

  logic signed [TWidth+DiffWidth:0] te [3];
  logic [2:0][OffWidth-1:0]         off_q;
  logic signed [2*OffWidth-1:0]     osq [3];

  for (genvar c = 0; c < 3; c++) begin : g_edge
    ptd_mul #(.WA(TWidth + 1), .WB(DiffWidth)) u_te (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed({1'b0, t_eff})),
      .b_i   ($signed(e33[c])),
      .p_o   (te[c])
    );
    ptd_mul #(.WA(OffWidth), .WB(OffWidth)) u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(off_q[c])),
      .b_i   ($signed(off_q[c])),
      .p_o   (osq[c])
    );
  end

  // offset from the edge point to the point, scaled by 2^24
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        off_q[c] <= (OffWidth'($signed(s35[c])) <<< EdgeFrac) - OffWidth'(te[c]);
      end
    end
  end

  // squared length, drop the 2^48 scale, saturate
  logic [SqWidth-1:0]                sq_sum;
  logic [SqWidth-2*EdgeFrac-1:0]     sq_sh;
  logic [DistWidth-1:0]              edist_d, edist_q, edist63;

  always_comb begin
    sq_sum  = SqWidth'(osq[0]) + SqWidth'(osq[1]) + SqWidth'(osq[2]);
    sq_sh   = sq_sum[SqWidth-1:2*EdgeFrac];
    edist_d = (|sq_sh[SqWidth-2*EdgeFrac-1:DistWidth]) ? '1 : sq_sh[DistWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      edist_q <= edist_d;
    end
  end

  ptd_dly #(.WIDTH(DistWidth), .DEPTH(TailDelay)) u_edist_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (edist_q),
    .q_o   (edist63)
  );

  // face path: floor(pd^2 / nn), top quotient bit means saturation
  logic signed [Pd2Width-1:0] pd2;
  logic [NnWidth-1:0]         nn10;
  logic [DistWidth:0]         fq;

  ptd_mul #(.WA(PdWidth), .WB(PdWidth)) u_pd2 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   ($signed(pd8_q)),
    .b_i   ($signed(pd8_q)),
    .p_o   (pd2)
  );

  ptd_dly #(.WIDTH(NnWidth), .DEPTH(2)) u_nn_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (nn8_q),
    .q_o   (nn10)
  );

  ptd_div #(.DW(FaceRemWidth), .FEED(DistWidth)) u_face_div (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (FaceRemWidth'(pd2[Pd2Width-1:DistWidth])),
    .den_i (FaceRemWidth'(nn10)),
    .low_i (pd2[DistWidth-1:0]),
    .quo_o (fq)
  );

  // region, flag and vertex distance ride along
  logic [2:0]          reg63_bits;
  region_e             reg63;
  logic                deg63;
  logic [DotWidth-1:0] vdist63;

  ptd_dly #(.WIDTH(MetaWidth), .DEPTH(MetaDelay)) u_meta_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({region_q, deg_q, vdist_q}),
    .q_o   ({reg63_bits, deg63, vdist63})
  );

  assign reg63 = region_e'(reg63_bits);

  // output word
  logic [DistWidth-1:0] dist_d;
  ptd_out_t             out_q;

  always_comb begin
    case (reg63) inside
      RegionVertexA, RegionVertexB, RegionVertexC: dist_d = DistWidth'(vdist63);
      RegionEdgeAB, RegionEdgeAC, RegionEdgeBC:    dist_d = edist63;
      RegionFace: begin
        if (deg63) begin
          dist_d = '0;
        end else if (fq[DistWidth]) begin
          dist_d = '1;
        end else begin
          dist_d = fq[DistWidth-1:0];
        end
      end
      default: dist_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.distance_squared <= dist_d;
      out_q.closest_region   <= reg63;
      out_q.degenerate       <= deg63;
    end
  end

  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted word did not enter the pipe");

  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && in_ready_o |=> !vld_q[0])
    else $error("bubble became a valid word");

  a_deg_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.closest_region == RegionFace)
    else $error("degenerate flag outside the face region");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.distance_squared == '0)
    else $error("degenerate word with nonzero distance");
`endif

endmodule

`default_nettype wire

>>> rtl/ptd_dly.sv
// ptd_dly: enabled shift line that keeps side data aligned with the pipe.
// No package dependencies.
`default_nettype none

module ptd_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sr_q [DEPTH];

  // shift one place per advancing cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/ptd_mul.sv
// ptd_mul: two-stage signed multiplier, operands cut into slices whose
// partial products are registered and then summed. Uses ptd_pkg defaults.
`default_nettype none

module ptd_mul #(
  parameter int WA = 26,
  parameter int WB = 26,
  parameter int PW = ptd_pkg::PieceWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [WA-1:0]  a_i,
  input  wire logic signed [WB-1:0]  b_i,
  output logic signed [WA+WB-1:0]    p_o
);

  localparam int NA    = (WA + PW - 1) / PW;
  localparam int NB    = (WB + PW - 1) / PW;
  localparam int EA    = NA * PW;
  localparam int EB    = NB * PW;
  localparam int PartW = 2 * PW + 2;
  localparam int AccW  = EA + EB + 2;

  logic [EA-1:0] a_ext;
  logic [EB-1:0] b_ext;
  logic signed [PartW-1:0] part_q [NA][NB];
  logic signed [AccW-1:0]  acc;
  logic signed [WA+WB-1:0] p_q;

  assign a_ext = EA'(a_i);
  assign b_ext = EB'(b_i);

  // slice products: top slice signed, the others unsigned
  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      logic signed [PW:0] pa, pb;
      assign pa = (i == NA - 1) ? {a_ext[i*PW+PW-1], a_ext[i*PW +: PW]}
                                : {1'b0, a_ext[i*PW +: PW]};
      assign pb = (j == NB - 1) ? {b_ext[j*PW+PW-1], b_ext[j*PW +: PW]}
                                : {1'b0, b_ext[j*PW +: PW]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          part_q[i][j] <= PartW'(pa) * PartW'(pb);
        end
      end
    end
  end

  // weighted sum of the slice products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (AccW'(part_q[i][j]) <<< (PW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[WA+WB-1:0];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> rtl/ptd_div.sv
// ptd_div: pipelined restoring divider, one quotient bit per stage.
// First stage tests rem_i >= den_i, then FEED dividend bits are shifted in.
`default_nettype none

module ptd_div #(
  parameter int DW   = 8,
  parameter int FEED = 8
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [DW-1:0]   rem_i,
  input  wire logic [DW-1:0]   den_i,
  input  wire logic [FEED-1:0] low_i,
  output logic      [FEED:0]   quo_o
);

  logic [DW-1:0]   rem_q [FEED+1];
  logic [DW-1:0]   den_q [FEED+1];
  logic [FEED-1:0] low_q [FEED+1];
  logic [FEED:0]   quo_q [FEED+1];

  // top quotient bit: whole remainder against divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (rem_i >= den_i) ? rem_i - den_i : rem_i;
      quo_q[0] <= {{FEED{1'b0}}, (rem_i >= den_i)};
      den_q[0] <= den_i;
      low_q[0] <= low_i;
    end
  end

  // one shift, trial subtract and select per stage
  for (genvar k = 1; k <= FEED; k++) begin : g_step
    logic [DW:0] shifted;
    logic [DW:0] trial;
    logic        take;
    assign shifted = {rem_q[k-1], low_q[k-1][FEED-1]};
    assign trial   = shifted - {1'b0, den_q[k-1]};
    assign take    = ~trial[DW];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? trial[DW-1:0] : shifted[DW-1:0];
        quo_q[k] <= {quo_q[k-1][FEED-1:0], take};
        den_q[k] <= den_q[k-1];
        low_q[k] <= low_q[k-1] << 1;
      end
    end
  end

  assign quo_o = quo_q[FEED];

endmodule

`default_nettype wire

>>> tb/point_triangle_distance_squared_tb.sv
// point_triangle_distance_squared_tb: self-checking bench for the point-triangle
// squared distance pipeline, with its own wide-integer predictor and a scoreboard.
// Depends on ptd_pkg and the point_triangle_distance_squared RTL.
`default_nettype none

module point_triangle_distance_squared_tb;
  import ptd_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    wide_t x, y, z;
  } vec_t;

  localparam int    IdleLimit = 4000;
  localparam int    DrainWait = 120;
  localparam wide_t OneQ24    = wide_t'(1) <<< 24;
  localparam wide_t DistMax   = (wide_t'(1) <<< 52) - 1;
  localparam int    Unit      = 4096;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready_o;
  ptd_in_t  in_data;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  ptd_out_t out_data_o;

  ptd_out_t expected_words[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       snd_idle_pct;
  int       rcv_idle_pct;
  logic     any_accept = 1'b0;

  point_triangle_distance_squared u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // vector helpers over exact wide integers
  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic wide_t vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // squared distance to a point on the edge, fraction truncated to 24 bits
  function automatic wide_t edge_dist(vec_t s, vec_t e, wide_t num, wide_t den);
    wide_t t, ox, oy, oz;
    t = 0;
    if (den != 0) t = (num * OneQ24) / den;
    ox = s.x * OneQ24 - t * e.x;
    oy = s.y * OneQ24 - t * e.y;
    oz = s.z * OneQ24 - t * e.z;
    return (ox * ox + oy * oy + oz * oz) >> 48;
  endfunction

  // closest-region selection and distance for one word
  function automatic ptd_out_t predict_distance(ptd_in_t w);
    vec_t     p, a, b, c, ab, ac, ap, bp, cp, nrm;
    wide_t    d1, d2, d3, d4, d5, d6, vc, vb, va, e1, e2, nn, pd, dsq;
    region_e  region;
    logic     deg;
    ptd_out_t r;
    p.x = wide_t'(w.point_x);    p.y = wide_t'(w.point_y);    p.z = wide_t'(w.point_z);
    a.x = wide_t'(w.vertex_a_x); a.y = wide_t'(w.vertex_a_y); a.z = wide_t'(w.vertex_a_z);
    b.x = wide_t'(w.vertex_b_x); b.y = wide_t'(w.vertex_b_y); b.z = wide_t'(w.vertex_b_z);
    c.x = wide_t'(w.vertex_c_x); c.y = wide_t'(w.vertex_c_y); c.z = wide_t'(w.vertex_c_z);
    ab = vsub(b, a); ac = vsub(c, a); ap = vsub(p, a);
    bp = vsub(p, b); cp = vsub(p, c);
    d1 = vdot(ab, ap); d2 = vdot(ac, ap);
    d3 = vdot(ab, bp); d4 = vdot(ac, bp);
    d5 = vdot(ab, cp); d6 = vdot(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    e1 = d4 - d3;
    e2 = d5 - d6;
    dsq = 0;
    deg = 1'b0;
    if (d1 <= 0 && d2 <= 0) begin
      region = RegionVertexA; dsq = vdot(ap, ap);
    end else if (d3 >= 0 && d4 <= d3) begin
      region = RegionVertexB; dsq = vdot(bp, bp);
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      region = RegionEdgeAB; dsq = edge_dist(ap, ab, d1, d1 - d3);
    end else if (d6 >= 0 && d5 <= d6) begin
      region = RegionVertexC; dsq = vdot(cp, cp);
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      region = RegionEdgeAC; dsq = edge_dist(ap, ac, d2, d2 - d6);
    end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
      region = RegionEdgeBC; dsq = edge_dist(bp, vsub(c, b), e1, e1 + e2);
    end else begin
      region = RegionFace;
      nrm.x = ab.y * ac.z - ab.z * ac.y;
      nrm.y = ab.z * ac.x - ab.x * ac.z;
      nrm.z = ab.x * ac.y - ab.y * ac.x;
      nn = vdot(nrm, nrm);
      if (nn == 0) begin
        deg = 1'b1;
      end else begin
        pd = vdot(ap, nrm);
        dsq = (pd * pd) / nn;
      end
    end
    if (dsq < 0) dsq = 0;
    if (dsq > DistMax) dsq = DistMax;
    r.distance_squared = dsq[DistWidth-1:0];
    r.closest_region   = region;
    r.degenerate       = deg;
    return r;
  endfunction

  // receiver ready, random stalls
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result checker, sampled mid-cycle where all signals are settled
  always @(negedge clk_i) begin
    ptd_out_t want;
    any_accept = (in_valid && in_ready_o) || (out_valid_o && out_ready);
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data_o);
      end else begin
        want = expected_words.pop_front();
        if (out_data_o.distance_squared !== want.distance_squared ||
            out_data_o.closest_region !== want.closest_region ||
            out_data_o.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected dist %h region %0d deg %b, got dist %h region %0d deg %b",
                     want.distance_squared, want.closest_region, want.degenerate,
                     out_data_o.distance_squared, out_data_o.closest_region,
                     out_data_o.degenerate);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if (any_accept) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("point_triangle_distance_squared_tb: done, errors");
      $finish;
    end
  end

  // send one word; valid stays high across back-to-back words
  task automatic send_word(ptd_in_t w);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    expected_words.insert(expected_words.size(), predict_distance(w));
    @(posedge clk_i);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic ptd_in_t make_word(int px, int py, int pz, int ax, int ay, int az,
                                        int bx, int by, int bz, int cx, int cy, int cz);
    ptd_in_t w;
    w.point_x = px[23:0];    w.point_y = py[23:0];    w.point_z = pz[23:0];
    w.vertex_a_x = ax[23:0]; w.vertex_a_y = ay[23:0]; w.vertex_a_z = az[23:0];
    w.vertex_b_x = bx[23:0]; w.vertex_b_y = by[23:0]; w.vertex_b_z = bz[23:0];
    w.vertex_c_x = cx[23:0]; w.vertex_c_y = cy[23:0]; w.vertex_c_z = cz[23:0];
    return w;
  endfunction

  // each region of a unit right triangle, extremes, zero normal, zero-length edge
  task automatic test_directed();
    int u, mx, mn;
    u  = Unit;
    mx = 8388607;
    mn = -8388608;
    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    send_word(make_word(-u, -u, 0, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(2*u, -u/8, u, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(u/2, -u, u, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(-u/8, 2*u, 0, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(-u, u/2, -u, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(u, u, u/3, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(u/4, u/4, u, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(u/4, u/4, -u, 0, 0, 0, u, 0, 0, 0, u, 0));
    send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(u, u, u, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(u, u, 0, 0, 0, 0, 2*u, 0, 0, u, 0, 0));
    send_word(make_word(u, 0, u, 0, 0, 0, 0, 0, 0, 2*u, 0, 0));
    send_word(make_word(u, u, u, u, 0, 0, u, 0, 0, u, 0, 0));
    send_word(make_word(mx, mx, mx, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_word(make_word(mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mx));
    send_word(make_word(mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mx));
    send_word(make_word(mx, mx, mx, mn, mn, mn, mn, mn, mx, mx, mn, mn));
    send_word(make_word(-1, -1, -1, mx, mx, mx, mn, mx, mx, mx, mn, mx));
    send_word(make_word(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_word(make_word(mx, 0, 0, mn, 0, 0, mx, 0, 0, 0, mx, 0));
    send_word(make_word(1, 1, 1, 0, 0, 0, 3, 0, 0, 0, 3, 0));
  endtask

  // mostly small triangles around a random center, some full-range words
  function automatic ptd_in_t random_word();
    ptd_in_t w;
    logic [23:0] f[12];
    int center[3], span, k;
    if ($urandom_range(3) == 0) begin
      foreach (f[i]) f[i] = 24'($urandom());
    end else begin
      span = 1 << $urandom_range(16, 4);
      for (k = 0; k < 3; k++) center[k] = $signed($urandom_range(65535, 0)) * 64 - 2097152;
      foreach (f[i]) f[i] = 24'(center[i % 3] + $signed($urandom_range(2 * span)) - span);
      if ($urandom_range(7) == 0) begin
        for (k = 0; k < 3; k++) f[9 + k] = f[6 + k];
      end
      if ($urandom_range(7) == 0) begin
        for (k = 0; k < 3; k++) f[9 + k] = 24'((f[3 + k] + f[6 + k]) >>> 1);
      end
    end
    w = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
    return w;
  endfunction

  task automatic test_random(int count, int snd_pct, int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (count) send_word(random_word());
  endtask

  // sender holds off until the pipe has drained
  task automatic test_drain_pause();
    go_idle();
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(280, 7, 75);
    test_drain_pause();
    test_random(280, 75, 7);
    test_random(290, 0, 0);
    go_idle();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("point_triangle_distance_squared_tb: done, clean");
    end else begin
      $display("point_triangle_distance_squared_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
